FILE: design/assert_macros.svh
// Assertion helpers used by the checker file bold_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bold_pkg.sv
package bold_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int OP_W     = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 3;
  localparam int ECOUNT_W = 9;

  localparam logic [OP_W-1:0] OP_APPEND   = 2'd0;
  localparam logic [OP_W-1:0] OP_DEL_HEAD = 2'd1;
  localparam logic [OP_W-1:0] OP_DEL_TAIL = 2'd2;
  localparam logic [OP_W-1:0] OP_DEL_POS  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

FILE: design/bold_ctrl.sv
module bold_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output bold_pkg::cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;

  // A new beat is taken unless a result is waiting and the receiver stalls.
  assign in_stall  = (state_r == S_HOLD) && out_stall;
  assign out_valid = (state_r == S_HOLD);
  assign cmd.exec  = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.exec) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (cmd.exec) state_nxt = S_HOLD;
        else if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

FILE: design/bold_dp.sv
module bold_dp #(
  parameter int DEPTH = bold_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bold_pkg::cmd_t                      cmd,
  input  logic        [bold_pkg::OP_W-1:0]    in_operation,
  input  logic signed [bold_pkg::VALUE_W-1:0] in_value,
  input  logic        [bold_pkg::POS_W-1:0]   in_position,
  output logic        [bold_pkg::STATUS_W-1:0] out_status,
  output logic signed [bold_pkg::VALUE_W-1:0] out_removed_value,
  output logic        [bold_pkg::ECOUNT_W-1:0] out_entry_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = bold_pkg::ECOUNT_W;

  logic signed [bold_pkg::VALUE_W-1:0] cell_r [DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  logic [IW-1:0] del_idx;
  logic          add_ok;
  logic          del_ok;
  logic [bold_pkg::STATUS_W-1:0] status_nxt;
  logic [EW-1:0] count_ext;
  logic [EW-1:0] pos_ext;

  assign count_ext = EW'(count_r);
  assign pos_ext   = EW'(in_position);

  always_comb begin
    add_ok     = 1'b0;
    del_ok     = 1'b0;
    del_idx    = '0;
    status_nxt = bold_pkg::ST_EMPTY;
    case (in_operation)
      bold_pkg::OP_APPEND: begin
        if (count_ext == EW'(DEPTH)) begin
          status_nxt = bold_pkg::ST_FULL;
        end else begin
          add_ok     = 1'b1;
          status_nxt = bold_pkg::ST_APPENDED;
        end
      end
      bold_pkg::OP_DEL_HEAD: begin
        del_idx = '0;
        if (count_r != '0) begin
          del_ok     = 1'b1;
          status_nxt = bold_pkg::ST_DELETED;
        end
      end
      bold_pkg::OP_DEL_TAIL: begin
        del_idx = IW'(count_r - CW'(1));
        if (count_r != '0) begin
          del_ok     = 1'b1;
          status_nxt = bold_pkg::ST_DELETED;
        end
      end
      bold_pkg::OP_DEL_POS: begin
        // A good position is at most count, so position minus one fits the index.
        del_idx = IW'(pos_ext - EW'(1));
        if (count_r == '0) begin
          status_nxt = bold_pkg::ST_EMPTY;
        end else if (in_position == '0 || pos_ext > count_ext) begin
          status_nxt = bold_pkg::ST_RANGE;
        end else begin
          del_ok     = 1'b1;
          status_nxt = bold_pkg::ST_DELETED;
        end
      end
      default: status_nxt = bold_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (add_ok) count_nxt = count_r + CW'(1);
    else if (del_ok) count_nxt = count_r - CW'(1);
  end

  // Each cell loads the appended value, takes its neighbor, or holds.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (add_ok && CW'(k) == count_r) begin
          cell_r[IW'(k)] <= in_value;
        end else if (del_ok && IW'(k) >= del_idx && k < DEPTH - 1) begin
          cell_r[IW'(k)] <= cell_r[IW'(k + 1)];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status        <= status_nxt;
      out_removed_value <= del_ok ? cell_r[del_idx] : '0;
      out_entry_count   <= EW'(count_nxt);
    end
  end

endmodule

FILE: design/bounded_ordered_list_delete_core.sv
// Bounded ordered list of signed 32-bit values, up to DEPTH entries.
// Input channel: in_operation, in_value, in_position with in_valid/in_stall.
// A beat is taken at a clock edge with in_valid high and in_stall low.
// Result channel: out_status, out_removed_value, out_entry_count with
// out_valid/out_stall; every request gives exactly one result beat.
// The result is valid in the cycle after the request is taken. Throughput
// is one request per cycle while no stalled result is waiting, set by the
// chain of entry cells that appends or closes the gap of a delete in place.
// The result sits in an output register; while it waits and out_stall is
// high, in_stall is high and no new request is taken. When the result is
// taken, a new request may be taken in the same cycle.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result. Entry cells are not cleared; only cells below the count are read.
module bounded_ordered_list_delete_core #(
  parameter int DEPTH = bold_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [bold_pkg::OP_W-1:0]     in_operation,
  input  logic signed [bold_pkg::VALUE_W-1:0]  in_value,
  input  logic        [bold_pkg::POS_W-1:0]    in_position,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic        [bold_pkg::STATUS_W-1:0] out_status,
  output logic signed [bold_pkg::VALUE_W-1:0]  out_removed_value,
  output logic        [bold_pkg::ECOUNT_W-1:0] out_entry_count
);

  bold_pkg::cmd_t cmd;

  bold_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bold_dp #(.DEPTH(DEPTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

endmodule

FILE: design/bold_checker.sv
`include "assert_macros.svh"

module bold_checker #(
  parameter int DEPTH = bold_pkg::DEPTH_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic        [bold_pkg::STATUS_W-1:0] out_status,
  input logic signed [bold_pkg::VALUE_W-1:0]  out_removed_value,
  input logic        [bold_pkg::ECOUNT_W-1:0] out_entry_count
);

  localparam int EW = bold_pkg::ECOUNT_W;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_removed_value) && $stable(out_entry_count), "stalled result beat changed")
  `ASSERT_NOW(a_removed_zero, clk, rst_n, out_valid && out_status != bold_pkg::ST_DELETED, out_removed_value == '0, "removed value not zero without a delete")
  `ASSERT_NOW(a_full_count, clk, rst_n, out_valid && out_status == bold_pkg::ST_FULL, out_entry_count == EW'(DEPTH), "full reported below depth")
  `ASSERT_NOW(a_empty_count, clk, rst_n, out_valid && out_status == bold_pkg::ST_EMPTY, out_entry_count == '0, "empty reported with entries held")
  `ASSERT_NEXT(a_take_result, clk, rst_n, in_valid && !in_stall, out_valid, "accepted request gave no result beat")

endmodule

bind bounded_ordered_list_delete_core bold_checker #(.DEPTH(DEPTH)) u_bold_checker (.*);

FILE: verif/bold_list_checker.sv
module bold_list_checker
  import bold_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic        [OP_W-1:0]      in_operation,
  input  logic signed [VALUE_W-1:0]   in_value,
  input  logic        [POS_W-1:0]     in_position,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic        [STATUS_W-1:0]  out_status,
  input  logic signed [VALUE_W-1:0]   out_removed_value,
  input  logic        [ECOUNT_W-1:0]  out_entry_count,
  output int                          fail_count,
  output int                          pending_results,
  output int                          results_seen,
  output int                          deleted_seen,
  output int                          empty_seen,
  output int                          range_seen,
  output int                          full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0]  removed_value;
    logic        [ECOUNT_W-1:0] entry_count;
  } list_result_t;

  logic signed [VALUE_W-1:0] list_cells [DEPTH];
  int                        held;
  list_result_t              expected_results [$];

  // Applies one request to the local copy of the list and returns its result.
  function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic signed [VALUE_W-1:0] val,
                                                 input logic [POS_W-1:0] pos);
    list_result_t r;
    int           victim;
    r.status        = ST_EMPTY;
    r.removed_value = '0;
    victim          = -1;
    if (op == OP_APPEND) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        list_cells[held] = val;
        held++;
        r.status = ST_APPENDED;
      end
    end else if (held != 0) begin
      case (op)
        OP_DEL_HEAD: victim = 0;
        OP_DEL_TAIL: victim = held - 1;
        default: begin
          // An empty list wins over a bad position, so this is checked only here.
          if (pos == '0 || int'(pos) > held) r.status = ST_RANGE;
          else victim = int'(pos) - 1;
        end
      endcase
    end
    if (victim >= 0) begin
      r.removed_value = list_cells[victim];
      for (int k = victim; k < held - 1; k++) list_cells[k] = list_cells[k + 1];
      held--;
      r.status = ST_DELETED;
    end
    r.entry_count = ECOUNT_W'(held);
    return r;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      held = 0;
      expected_results.delete();
      pending_results = 0;
    end else begin
      // A result taken at this edge always belongs to an earlier request.
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding: status %0d", out_status);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          case (want.status)
            ST_DELETED: deleted_seen++;
            ST_EMPTY:   empty_seen++;
            ST_RANGE:   range_seen++;
            ST_FULL:    full_seen++;
            default: ;
          endcase
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fail_count++;
          end
          if (out_removed_value !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d",
                   want.removed_value, out_removed_value);
            fail_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, out_entry_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_request(in_operation, in_value, in_position));
      pending_results = expected_results.size();
    end
  end

endmodule

FILE: verif/tb_bounded_ordered_list_delete_core.sv
module tb_bounded_ordered_list_delete_core;
  timeunit 1ns;
  timeprecision 1ps;
  import bold_pkg::*;

  localparam int DEPTH            = DEPTH_DEF;
  localparam int CLK_PERIOD       = 10;
  localparam int RANDOM_ITEMS     = 1700;
  localparam int QUIET_TAIL       = 200;
  localparam int LONG_HOLD_AFTER  = 800;
  localparam int LONG_HOLD_CYCLES = 60;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic        [OP_W-1:0]     in_operation = OP_APPEND;
  logic signed [VALUE_W-1:0]  in_value     = '0;
  logic        [POS_W-1:0]    in_position  = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic        [STATUS_W-1:0] out_status;
  logic signed [VALUE_W-1:0]  out_removed_value;
  logic        [ECOUNT_W-1:0] out_entry_count;

  bit traffic_gaps   = 1'b1;
  int requests_sent  = 0;
  int fail_count;
  int pending_results;
  int results_seen;
  int deleted_seen;
  int empty_seen;
  int range_seen;
  int full_seen;

  bounded_ordered_list_delete_core #(.DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count)
  );

  bold_list_checker #(.DEPTH(DEPTH)) list_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_removed_value (out_removed_value),
    .out_entry_count   (out_entry_count),
    .fail_count        (fail_count),
    .pending_results   (pending_results),
    .results_seen      (results_seen),
    .deleted_seen      (deleted_seen),
    .empty_seen        (empty_seen),
    .range_seen        (range_seen),
    .full_seen         (full_seen)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [VALUE_W-1:0] pick_value(input int sel);
    case (sel)
      0:       return {1'b1, {(VALUE_W-1){1'b0}}};
      1:       return {1'b0, {(VALUE_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return POS_W'($urandom);
      default: return POS_W'($urandom_range(1, DEPTH + 1));
    endcase
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic signed [VALUE_W-1:0] val,
                              input logic [POS_W-1:0] pos);
    if (traffic_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    in_position  <= pos;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  // Result side: short random stalls, plus one long hold that backs the block up.
  initial begin
    int  n;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && requests_sent >= LONG_HOLD_AFTER) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (traffic_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int              mode;
    int              append_pct;
    logic [OP_W-1:0] op;
    mode = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Deletes of every kind on an empty list, with stray value bits.
    send_request(OP_DEL_HEAD, 32'sh5A5A5A5A, 8'd1);
    send_request(OP_DEL_TAIL, '1, 8'd0);
    send_request(OP_DEL_POS, '0, 8'd0);
    send_request(OP_DEL_POS, pick_value(1), 8'd255);
    // Fill to the top, then one append too many.
    for (int i = 0; i < DEPTH; i++) send_request(OP_APPEND, pick_value(i), POS_W'($urandom));
    send_request(OP_APPEND, 32'sd12345, 8'd0);
    send_request(OP_DEL_POS, pick_value(3), 8'd0);
    send_request(OP_DEL_POS, pick_value(0), POS_W'(DEPTH + 1));
    send_request(OP_DEL_POS, '0, 8'd1);
    send_request(OP_DEL_POS, '0, POS_W'(DEPTH - 1));
    send_request(OP_DEL_POS, '0, 8'd7);
    send_request(OP_DEL_HEAD, '0, 8'd0);
    send_request(OP_DEL_TAIL, '0, 8'd0);

    // Random part in chunks that lean toward filling, draining or mixing,
    // so that both the full and the empty list come up again and again.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) mode = $urandom_range(0, 2);
      if (i == RANDOM_ITEMS - QUIET_TAIL) traffic_gaps = 1'b0;
      append_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 50;
      if ($urandom_range(0, 99) < append_pct) begin
        op = OP_APPEND;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = OP_DEL_HEAD;
          1:       op = OP_DEL_TAIL;
          default: op = OP_DEL_POS;
        endcase
      end
      send_request(op, pick_value($urandom_range(0, 11)), pick_position());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d deletes, %0d on an empty list,",
             requests_sent, results_seen, deleted_seen, empty_seen);
    $display("%0d bad positions and %0d appends refused on a full list.",
             range_seen, full_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: bounded_ordered_list_delete_core.f
+incdir+design
design/bold_pkg.sv
design/bold_ctrl.sv
design/bold_dp.sv
design/bounded_ordered_list_delete_core.sv
design/bold_checker.sv
verif/bold_list_checker.sv
verif/tb_bounded_ordered_list_delete_core.sv
